// ===== rtl/ble_link_state_tracker_macros.svh =====
// Assertion macros used by the link state tracker FSM module
`ifndef BLE_LINK_STATE_TRACKER_MACROS_SVH
`define BLE_LINK_STATE_TRACKER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BLETRK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define BLETRK_ASSERT_IMP(label, ante, cons, msg) \
  `BLETRK_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BLETRK_ASSERT_NEXT(label, ante, cons, msg) \
  `BLETRK_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/bletrk_pkg.sv =====
// Shared types and codes of the BLE link state tracker
package bletrk_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_PERIPH  = 2'd1;
  localparam logic [1:0] MODE_CENTRAL = 2'd2;

  // Bit positions in the token found vector
  localparam int unsigned FOUND_BLE     = 0;
  localparam int unsigned FOUND_DISCONN = 1;
  localparam int unsigned FOUND_CONN    = 2;

  typedef enum logic [1:0] {
    STOP_NONE = 2'd0,
    STOP_ADV  = 2'd1,
    STOP_SCAN = 2'd2
  } stop_e;

  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_INIT_PERIPH  = 3'd1,
    CMD_INIT_CENTRAL = 3'd2,
    CMD_ADV_START    = 3'd3,
    CMD_SCAN_START   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic       op;
    logic [7:0] urc_byte;
    logic       line_end;
    logic       cmd_ok;
  } item_t;

  typedef struct packed {
    logic [3:0] link_state;
    logic       step_error;
    stop_e      stop_command;
    cmd_e       command;
  } result_t;

endpackage

// ===== rtl/bletrk_in_reg.sv =====
// Input register stage of the link state tracker
module bletrk_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bletrk_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            advance_i,
  output bletrk_pkg::item_t item_o
);
  import bletrk_pkg::*;

  logic  valid_q;
  item_t item_q;

  // Take a new item when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/bletrk_match.sv =====
// Case-insensitive substring matchers for BLE, DISCONN and CONN
module bletrk_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] ch_i,
  input  logic       line_end_i,
  output logic [2:0] found_o
);
  import bletrk_pkg::*;

  localparam logic [7:0] TOK_BLE [3] = '{"B", "L", "E"};
  localparam logic [7:0] TOK_DISC [7] = '{"D", "I", "S", "C", "O", "N", "N"};
  localparam logic [7:0] TOK_CONN [4] = '{"C", "O", "N", "N"};

  logic [1:0] ble_prog_q, ble_prog_d;
  logic [2:0] disc_prog_q, disc_prog_d;
  logic [1:0] conn_prog_q, conn_prog_d;
  logic [2:0] found_q, found_d;
  logic       ble_found_d, disc_found_d, conn_found_d;
  logic [7:0] ch_up;

  // Fold ASCII lower case letters only
  assign ch_up = (ch_i inside {["a":"z"]}) ? (ch_i - 8'd32) : ch_i;

  always_comb begin
    logic [1:0] p;
    ble_prog_d  = ble_prog_q;
    ble_found_d = found_q[FOUND_BLE];
    p = (ble_prog_q >= 2'd3) ? 2'd0 : ble_prog_q;
    if (!found_q[FOUND_BLE]) begin
      if (ch_up == TOK_BLE[p]) begin
        if (p == 2'd2) begin
          ble_found_d = 1'b1;
          ble_prog_d  = 2'd0;
        end else begin
          ble_prog_d = p + 2'd1;
        end
      end else begin
        ble_prog_d = (ch_up == TOK_BLE[0]) ? 2'd1 : 2'd0;
      end
    end
  end

  always_comb begin
    logic [2:0] p;
    disc_prog_d  = disc_prog_q;
    disc_found_d = found_q[FOUND_DISCONN];
    p = (disc_prog_q >= 3'd7) ? 3'd0 : disc_prog_q;
    if (!found_q[FOUND_DISCONN]) begin
      if (ch_up == TOK_DISC[p]) begin
        if (p == 3'd6) begin
          disc_found_d = 1'b1;
          disc_prog_d  = 3'd0;
        end else begin
          disc_prog_d = p + 3'd1;
        end
      end else begin
        disc_prog_d = (ch_up == TOK_DISC[0]) ? 3'd1 : 3'd0;
      end
    end
  end

  always_comb begin
    conn_prog_d  = conn_prog_q;
    conn_found_d = found_q[FOUND_CONN];
    if (!found_q[FOUND_CONN]) begin
      if (ch_up == TOK_CONN[conn_prog_q]) begin
        if (conn_prog_q == 2'd3) begin
          conn_found_d = 1'b1;
          conn_prog_d  = 2'd0;
        end else begin
          conn_prog_d = conn_prog_q + 2'd1;
        end
      end else begin
        conn_prog_d = (ch_up == TOK_CONN[0]) ? 2'd1 : 2'd0;
      end
    end
  end

  always_comb begin
    found_d                = '0;
    found_d[FOUND_BLE]     = ble_found_d;
    found_d[FOUND_DISCONN] = disc_found_d;
    found_d[FOUND_CONN]    = conn_found_d;
  end

  // The line evaluation sees the matches including this byte
  assign found_o = found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ble_prog_q  <= '0;
      disc_prog_q <= '0;
      conn_prog_q <= '0;
      found_q     <= '0;
    end else if (en_i) begin
      if (line_end_i) begin
        ble_prog_q  <= '0;
        disc_prog_q <= '0;
        conn_prog_q <= '0;
        found_q     <= '0;
      end else begin
        ble_prog_q  <= ble_prog_d;
        disc_prog_q <= disc_prog_d;
        conn_prog_q <= conn_prog_d;
        found_q     <= found_d;
      end
    end
  end

endmodule

// ===== rtl/bletrk_fsm.sv =====
// Role and link state machine of the tracker
`include "ble_link_state_tracker_macros.svh"

module bletrk_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                en_i,
  input  bletrk_pkg::item_t   item_i,
  input  logic [2:0]          found_i,
  output bletrk_pkg::result_t result_o
);
  import bletrk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_P_INIT = 4'd1,
    ST_P_ADV  = 4'd2,
    ST_P_WAIT = 4'd3,
    ST_P_CONN = 4'd4,
    ST_P_DISC = 4'd5,
    ST_C_INIT = 4'd6,
    ST_C_SCAN = 4'd7,
    ST_C_WAIT = 4'd8,
    ST_C_CONN = 4'd9,
    ST_C_DISC = 4'd10,
    ST_ERROR  = 4'd11
  } state_e;

  state_e     link_state_q, link_state_d;
  logic [1:0] active_mode_q, active_mode_d;
  logic [1:0] work_mode_q;
  stop_e      stop_cmd;
  cmd_e       cmd;
  logic       byte_en, step_en;

  assign byte_en = en_i && (item_i.op == OP_BYTE);
  assign step_en = en_i && (item_i.op == OP_STEP);

  always_comb begin
    state_e s;
    state_e next;
    logic   ok;
    logic   is_init;
    link_state_d  = link_state_q;
    active_mode_d = active_mode_q;
    stop_cmd      = STOP_NONE;
    cmd           = CMD_NONE;
    ok            = item_i.cmd_ok;
    s             = link_state_q;
    next          = link_state_q;
    is_init       = 1'b0;
    if (item_i.op == OP_BYTE) begin
      // Evaluate the line at its last byte; DISCONN wins over CONN
      if (item_i.line_end && found_i[FOUND_BLE]) begin
        if (found_i[FOUND_DISCONN]) begin
          link_state_d = (active_mode_q == MODE_CENTRAL) ? ST_C_DISC : ST_P_DISC;
        end else if (found_i[FOUND_CONN]) begin
          link_state_d = (active_mode_q == MODE_CENTRAL) ? ST_C_CONN : ST_P_CONN;
        end
      end
    end else begin
      // Role change: stop the old role and restart from the new role's init, or idle for no role
      if (active_mode_q != work_mode_q) begin
        if (active_mode_q == MODE_PERIPH) begin
          stop_cmd = STOP_ADV;
        end else if (active_mode_q == MODE_CENTRAL) begin
          stop_cmd = STOP_SCAN;
        end
        active_mode_d = work_mode_q;
        if (work_mode_q == MODE_PERIPH) begin
          s = ST_P_INIT;
        end else if (work_mode_q == MODE_CENTRAL) begin
          s = ST_C_INIT;
        end else begin
          s = ST_IDLE;
        end
      end
      is_init = s inside {ST_P_INIT, ST_C_INIT};
      case (s)
        ST_P_DISC: link_state_d = ST_P_ADV;
        ST_C_DISC: link_state_d = ST_C_SCAN;
        ST_P_INIT, ST_C_INIT, ST_P_ADV, ST_C_SCAN: begin
          // The command follows the active role, not the state branch
          if (active_mode_d == MODE_PERIPH) begin
            cmd = is_init ? CMD_INIT_PERIPH : CMD_ADV_START;
          end else if (active_mode_d == MODE_CENTRAL) begin
            cmd = is_init ? CMD_INIT_CENTRAL : CMD_SCAN_START;
          end
          if (cmd == CMD_NONE) begin
            ok = 1'b1;
          end
          case (s)
            ST_P_INIT: next = ST_P_ADV;
            ST_P_ADV:  next = ST_P_WAIT;
            ST_C_INIT: next = ST_C_SCAN;
            default:   next = ST_C_WAIT;
          endcase
          link_state_d = ok ? next : ST_ERROR;
        end
        default: link_state_d = s;
      endcase
    end
  end

  assign result_o.link_state   = link_state_d;
  assign result_o.step_error   = (link_state_d >= ST_ERROR);
  assign result_o.stop_command = stop_cmd;
  assign result_o.command      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_state_q  <= ST_IDLE;
      active_mode_q <= MODE_NONE;
      work_mode_q   <= MODE_NONE;
    end else begin
      if (cfg_we_i) begin
        work_mode_q <= cfg_wdata_i;
      end
      if (en_i) begin
        link_state_q  <= link_state_d;
        active_mode_q <= active_mode_d;
      end
    end
  end

  `BLETRK_ASSERT_IMP(a_stop_on_change, step_en && (stop_cmd != STOP_NONE),
    active_mode_q != work_mode_q, "stop command without a role change")
  `BLETRK_ASSERT_NEXT(a_role_follows, step_en,
    active_mode_q == $past(work_mode_q), "active role differs after a step")
  `BLETRK_ASSERT_IMP(a_conn_by_line,
    (link_state_q == ST_P_CONN) && ($past(link_state_q) != ST_P_CONN),
    $past(byte_en && item_i.line_end), "connected state entered outside a line end")

endmodule

// ===== rtl/bletrk_out_reg.sv =====
// Result register stage of the link state tracker
module bletrk_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  bletrk_pkg::result_t result_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bletrk_pkg::result_t result_o
);
  import bletrk_pkg::*;

  logic    valid_q;
  result_t result_q;

  // Hold a result until taken; refill in the same cycle it leaves
  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== rtl/ble_link_state_tracker.sv =====
// Top level of the BLE link state tracker
// An accepted item waits in the input register, then its result passes the
// state update logic into the result register and goes out on m_axis.
// One item per cycle while results are taken; each gives exactly one result.
// Ready falls only when the result register is held.
// Reset (rst_ni low, asynchronous): state idle, role none, matchers cleared.
module ble_link_state_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: work_mode register
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  // Input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] urc_byte, [8] cmd_ok, [15:9] zero
  input  logic        s_axis_tlast_i,  // line_end
  input  logic        s_axis_tuser_i,  // [0] op
  // Result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] link_state, [4] step_error, [6:5] stop_command, [9:7] command,
  // [15:10] zero
  output logic [15:0] m_axis_tdata_o
);
  import bletrk_pkg::*;

  item_t   in_item, cur_item;
  result_t step_result, out_result;
  logic    cur_valid, out_ready, step_en;
  logic [2:0] found;

  // Unpack the input item
  assign in_item.op       = s_axis_tuser_i;
  assign in_item.urc_byte = s_axis_tdata_i[7:0];
  assign in_item.line_end = s_axis_tlast_i;
  assign in_item.cmd_ok   = s_axis_tdata_i[8];

  bletrk_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (cur_valid),
    .advance_i (out_ready),
    .item_o    (cur_item)
  );

  // The held item is processed in the cycle it moves into the result register
  assign step_en = cur_valid && out_ready;

  bletrk_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (step_en && (cur_item.op == OP_BYTE)),
    .ch_i       (cur_item.urc_byte),
    .line_end_i (cur_item.line_end),
    .found_o    (found)
  );

  bletrk_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .en_i        (step_en),
    .item_i      (cur_item),
    .found_i     (found),
    .result_o    (step_result)
  );

  bletrk_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cur_valid),
    .ready_o  (out_ready),
    .result_i (step_result),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  // Pack the result item, first field in the low bits
  assign m_axis_tdata_o = {6'd0, out_result.command, out_result.stop_command,
                           out_result.step_error, out_result.link_state};

endmodule
